// ===== rtl/u2c_pkg.sv =====
// Package for the UTF-8 to CP874 transcoder: transfer payload types and
// the code point and byte constants of the CP874 mapping. No dependencies.
package u2c_pkg;

    // Input transfer: one UTF-8 byte and the end-of-string flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    // Result transfer: one optional CP874 byte and the end-of-string copy.
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       string_done;
    } t_out_item;

    localparam int CP_W = 21;

    // Thai block and its byte offset.
    localparam logic [CP_W-1:0] CP_THAI_FIRST = 21'h000E01;
    localparam logic [CP_W-1:0] CP_THAI_LAST  = 21'h000E5B;
    localparam logic [CP_W-1:0] CP_ASCII_END  = 21'h000080;
    localparam logic [7:0]      THAI_BYTE_OFS = 8'hA0;

    // Punctuation and symbol code points with a fixed CP874 byte.
    localparam logic [CP_W-1:0] CP_EURO     = 21'h0020AC;
    localparam logic [CP_W-1:0] CP_NBSP     = 21'h0000A0;
    localparam logic [CP_W-1:0] CP_ELLIPSIS = 21'h002026;
    localparam logic [CP_W-1:0] CP_LSQUO    = 21'h002018;
    localparam logic [CP_W-1:0] CP_RSQUO    = 21'h002019;
    localparam logic [CP_W-1:0] CP_LDQUO    = 21'h00201C;
    localparam logic [CP_W-1:0] CP_RDQUO    = 21'h00201D;
    localparam logic [CP_W-1:0] CP_BULLET   = 21'h002022;
    localparam logic [CP_W-1:0] CP_ENDASH   = 21'h002013;
    localparam logic [CP_W-1:0] CP_EMDASH   = 21'h002014;

    localparam logic [7:0] B_EURO     = 8'h80;
    localparam logic [7:0] B_NBSP     = 8'hA0;
    localparam logic [7:0] B_ELLIPSIS = 8'h85;
    localparam logic [7:0] B_LSQUO    = 8'h91;
    localparam logic [7:0] B_RSQUO    = 8'h92;
    localparam logic [7:0] B_LDQUO    = 8'h93;
    localparam logic [7:0] B_RDQUO    = 8'h94;
    localparam logic [7:0] B_BULLET   = 8'h95;
    localparam logic [7:0] B_ENDASH   = 8'h96;
    localparam logic [7:0] B_EMDASH   = 8'h97;

endpackage

// ===== rtl/u2c_map.sv =====
// Code point to CP874 byte mapper, purely combinational.
// Depends on u2c_pkg for the code point and byte constants.
module u2c_map
    import u2c_pkg::*;
(
    input  logic [CP_W-1:0] i_cp,
    output logic            o_hit,
    output logic [7:0]      o_byte
);

    // ASCII and the Thai block are ranges; the symbols are single points.
    always_comb begin
        o_hit  = 1'b1;
        o_byte = 8'h00;
        if (i_cp < CP_ASCII_END) begin
            o_byte = i_cp[7:0];
        end else if (i_cp >= CP_THAI_FIRST && i_cp <= CP_THAI_LAST) begin
            // The low byte of the Thai block is at most 0x5B, so no carry out.
            o_byte = i_cp[7:0] + THAI_BYTE_OFS;
        end else begin
            unique case (i_cp)
                CP_EURO:     o_byte = B_EURO;
                CP_NBSP:     o_byte = B_NBSP;
                CP_ELLIPSIS: o_byte = B_ELLIPSIS;
                CP_LSQUO:    o_byte = B_LSQUO;
                CP_RSQUO:    o_byte = B_RSQUO;
                CP_LDQUO:    o_byte = B_LDQUO;
                CP_RDQUO:    o_byte = B_RDQUO;
                CP_BULLET:   o_byte = B_BULLET;
                CP_ENDASH:   o_byte = B_ENDASH;
                CP_EMDASH:   o_byte = B_EMDASH;
                default:     o_hit  = 1'b0;
            endcase
        end
    end

endmodule

// ===== rtl/utf8_to_cp874_transcoder_unit.sv =====
// Top level of the UTF-8 to CP874 transcoder: decoder state, result
// register with skid stage. Depends on u2c_pkg and u2c_map.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//
// Every input transfer gives exactly one result transfer, from a register.
// One byte is taken each cycle while o_in_stall is low; the rate is set by
// the single decode step that updates the accumulator and the pending count.
// The skid stage holds one result while the output is stalled, so one more
// byte is taken before o_in_stall rises; o_in_stall comes from a register.
// Reset is synchronous and active low and clears the decoder state and both
// result slots.
module utf8_to_cp874_transcoder_unit
    import u2c_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [CP_W-1:0] r_code_accum, n_code_accum;
    logic [1:0]      r_bytes_rem, n_bytes_rem;
    logic            r_main_valid, r_skid_valid;
    t_out_item       r_main, r_skid;

    logic            in_xfer, out_xfer;
    logic            have_cp, map_hit;
    logic [CP_W-1:0] cp;
    logic [7:0]      map_byte, b;
    t_out_item       result;

    assign b          = i_in_data.in_byte;
    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign out_xfer   = r_main_valid && !i_out_stall;

    // UTF-8 decode step: continue a pending sequence or start a new lead.
    always_comb begin
        n_code_accum = r_code_accum;
        n_bytes_rem  = r_bytes_rem;
        have_cp      = 1'b0;
        cp           = '0;
        if (r_bytes_rem != 2'd0 && b[7:6] == 2'b10) begin
            n_code_accum = {r_code_accum[CP_W-7:0], b[5:0]};
            n_bytes_rem  = r_bytes_rem - 2'd1;
            if (n_bytes_rem == 2'd0) begin
                have_cp = 1'b1;
                cp      = n_code_accum;
            end
        end else begin
            // A pending sequence is dropped and this byte is a new lead.
            n_code_accum = '0;
            n_bytes_rem  = 2'd0;
            if (!b[7]) begin
                have_cp = 1'b1;
                cp      = {{(CP_W-8){1'b0}}, b};
            end else if (b[7:5] == 3'b110) begin
                n_code_accum = {{(CP_W-5){1'b0}}, b[4:0]};
                n_bytes_rem  = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_code_accum = {{(CP_W-4){1'b0}}, b[3:0]};
                n_bytes_rem  = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                n_code_accum = {{(CP_W-3){1'b0}}, b[2:0]};
                n_bytes_rem  = 2'd3;
            end
        end
        if (have_cp) begin
            n_code_accum = '0;
        end
        // An incomplete sequence at the end of a string is dropped.
        if (i_in_data.end_of_string) begin
            n_code_accum = '0;
            n_bytes_rem  = 2'd0;
        end
    end

    u2c_map u_map (
        .i_cp   (cp),
        .o_hit  (map_hit),
        .o_byte (map_byte)
    );

    // Result of this byte; the byte field is zero when nothing is produced.
    always_comb begin
        result.out_valid   = have_cp && map_hit;
        result.out_byte    = (have_cp && map_hit) ? map_byte : 8'h00;
        result.string_done = i_in_data.end_of_string;
    end

    // Decoder state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_accum <= '0;
            r_bytes_rem  <= 2'd0;
        end else if (in_xfer) begin
            r_code_accum <= n_code_accum;
            r_bytes_rem  <= n_bytes_rem;
        end
    end

    // Result register and skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (in_xfer) begin
                r_main <= result;
            end else begin
                r_main_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (r_main_valid) begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end else begin
                r_main       <= result;
                r_main_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_main_valid;
    assign o_out_data  = r_main;

    // The skid stage only fills behind a waiting result.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid stage holds a result with the result register empty");

    // A transfer taken while the output stalls lands in the skid stage.
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_main_valid && i_out_stall) |=> r_skid_valid)
        else $error("byte taken under output stall was lost");

    // The end of a string leaves the decoder idle.
    a_eos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.end_of_string) |=>
        (r_bytes_rem == 2'd0 && r_code_accum == '0))
        else $error("decoder state not cleared at end of string");

    // A dropped character shows a zero byte.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_valid) |-> (o_out_data.out_byte == 8'h00))
        else $error("dropped character carries a nonzero byte");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for utf8_to_cp874_transcoder_unit: directed and random UTF-8 strings,
// each result checked against a built-in model of the decoder. Depends on u2c_pkg.
module tb;
    import u2c_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int PHASE_BYTES = 490;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Decoder state of the model and the results it has predicted.
    logic [20:0] dec_accum = '0;
    logic [1:0]  dec_left = '0;
    t_out_item   expected_q[$];
    logic [7:0]  str_bytes[$];

    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int chars_out = 0;
    int strings_sent = 0;
    int error_count = 0;
    int cycle_count = 0;

    utf8_to_cp874_transcoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // CP874 byte of a code point; bit 8 is set when one exists.
    function automatic logic [8:0] cp874_of(input logic [20:0] cp);
        if (cp < CP_ASCII_END) begin
            return {1'b1, cp[7:0]};
        end
        if (cp >= CP_THAI_FIRST && cp <= CP_THAI_LAST) begin
            return {1'b1, THAI_BYTE_OFS + cp[7:0]};
        end
        case (cp)
            CP_EURO:     return {1'b1, B_EURO};
            CP_NBSP:     return {1'b1, B_NBSP};
            CP_ELLIPSIS: return {1'b1, B_ELLIPSIS};
            CP_LSQUO:    return {1'b1, B_LSQUO};
            CP_RSQUO:    return {1'b1, B_RSQUO};
            CP_LDQUO:    return {1'b1, B_LDQUO};
            CP_RDQUO:    return {1'b1, B_RDQUO};
            CP_BULLET:   return {1'b1, B_BULLET};
            CP_ENDASH:   return {1'b1, B_ENDASH};
            CP_EMDASH:   return {1'b1, B_EMDASH};
            default:     return 9'd0;
        endcase
    endfunction

    // Advances the decoder model by one byte and returns the expected result.
    function automatic t_out_item transcode_byte(input t_in_item it);
        t_out_item   res;
        logic [7:0]  b;
        logic        done;
        logic [20:0] cp;
        logic [8:0]  mapped;
        b = it.in_byte;
        done = 1'b0;
        cp = '0;
        res = '0;
        if (dec_left != 2'd0 && b[7:6] == 2'b10) begin
            dec_accum = {dec_accum[14:0], b[5:0]};
            dec_left = dec_left - 2'd1;
            if (dec_left == 2'd0) begin
                done = 1'b1;
                cp = dec_accum;
            end
        end else begin
            // A non-continuation byte drops whatever was pending.
            dec_left = 2'd0;
            dec_accum = '0;
            if (!b[7]) begin
                done = 1'b1;
                cp = {13'd0, b};
            end else if (b[7:5] == 3'b110) begin
                dec_accum = {16'd0, b[4:0]};
                dec_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                dec_accum = {17'd0, b[3:0]};
                dec_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                dec_accum = {18'd0, b[2:0]};
                dec_left = 2'd3;
            end
        end
        if (done) begin
            mapped = cp874_of(cp);
            res.out_valid = mapped[8];
            res.out_byte = mapped[7:0];
            dec_accum = '0;
        end
        if (it.end_of_string) begin
            dec_left = 2'd0;
            dec_accum = '0;
        end
        res.string_done = it.end_of_string;
        return res;
    endfunction

    // Appends the UTF-8 form of a code point in a given number of bytes.
    function automatic void append_utf8(input logic [20:0] cp, input int nbytes);
        case (nbytes)
            1: str_bytes.push_back({1'b0, cp[6:0]});
            2: begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [20:0] symbol_cp(input int k);
        case (k)
            0:       return CP_EURO;
            1:       return CP_NBSP;
            2:       return CP_ELLIPSIS;
            3:       return CP_LSQUO;
            4:       return CP_RSQUO;
            5:       return CP_LDQUO;
            6:       return CP_RDQUO;
            7:       return CP_BULLET;
            8:       return CP_ENDASH;
            default: return CP_EMDASH;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Sends one byte, with random idle cycles first, and records its result.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        t_in_item it;
        it.in_byte = b;
        it.end_of_string = eos;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_q.push_back(transcode_byte(it));
        bytes_sent++;
    endtask

    // Sends the collected string, flagging its last byte.
    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++) begin
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        end
        str_bytes.delete();
        strings_sent++;
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Each result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with no byte outstanding");
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                if (o_out_data.out_valid) chars_out++;
                if (o_out_data.out_valid !== want.out_valid)
                    report_mismatch($sformatf("out_valid %b, predicted %b",
                                              o_out_data.out_valid, want.out_valid));
                if (o_out_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %h, predicted %h",
                                              o_out_data.out_byte, want.out_byte));
                if (o_out_data.string_done !== want.string_done)
                    report_mismatch($sformatf("string_done %b, predicted %b",
                                              o_out_data.string_done, want.string_done));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("tb: timeout with %0d results outstanding", expected_q.size());
            $display("tb: errors");
            $finish;
        end
    end

    // ASCII extremes, the zero byte and an overlong NUL.
    task automatic test_ascii_edges();
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Both ends of the Thai block and the unmapped point just below it.
    task automatic test_thai_bounds();
        send_byte(8'hE0, 1'b0);
        send_byte(8'hB8, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hB9, 1'b0);
        send_byte(8'h9B, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hB8, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Fixed symbols in two and three byte forms; the rest come from random text.
    task automatic test_symbols();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA0, 1'b1);
    endtask

    // Stray continuation, invalid lead inside a sequence, broken sequence.
    task automatic test_malformed();
        send_byte(8'h80, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hB8, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // A four byte sequence cut off by the end of the string, then a byte
    // that must be seen as a stray continuation.
    task automatic test_string_end();
        send_byte(8'hF4, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hBF, 1'b1);
    endtask

    // Adds one random character, well-formed or not, to the string.
    task automatic add_random_char();
        int          pick;
        int          nbytes;
        logic [20:0] cp;
        pick = $urandom_range(99);
        if (pick < 30) begin
            append_utf8(21'($urandom_range(1, 127)), 1);
        end else if (pick < 60) begin
            append_utf8(21'(CP_THAI_FIRST - 1 + $urandom_range(0, 8'h5F)), 3);
        end else if (pick < 72) begin
            cp = symbol_cp($urandom_range(0, 9));
            append_utf8(cp, (cp == CP_NBSP) ? 2 : 3);
        end else if (pick < 80) begin
            nbytes = $urandom_range(2, 4);
            cp = (nbytes == 2) ? 21'($urandom_range(0, 11'h7FF)) :
                 (nbytes == 3) ? 21'($urandom_range(0, 16'hFFFF)) :
                                 21'($urandom_range(0, 21'h1FFFFF));
            append_utf8(cp, nbytes);
        end else if (pick < 86) begin
            // Overlong forms of ASCII and Thai points.
            if ($urandom_range(1)) begin
                append_utf8(21'($urandom_range(0, 127)), $urandom_range(2, 4));
            end else begin
                append_utf8(21'(CP_THAI_FIRST + $urandom_range(0, 8'h5A)), 4);
            end
        end else if (pick < 93) begin
            // Truncated sequence; the next byte breaks it or the string ends.
            nbytes = $urandom_range(2, 4);
            append_utf8(21'($urandom_range(0, 21'h1FFFFF)), nbytes);
            repeat ($urandom_range(1, nbytes - 1)) void'(str_bytes.pop_back());
        end else begin
            str_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
        end
    endtask

    // Random text in phases of different idling on both sides.
    task automatic test_random_text();
        int start_count;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin send_idle_pct = 72; out_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  out_stall_pct = 72; end
                default: begin send_idle_pct = 6; out_stall_pct = 6; end
            endcase
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES) begin
                repeat ($urandom_range(1, 10)) add_random_char();
                send_string();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ascii_edges();
        test_thai_bounds();
        test_symbols();
        test_malformed();
        test_string_end();
        test_random_text();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("tb: %0d bytes in %0d strings, %0d results checked, %0d gave a CP874 byte",
                 bytes_sent, strings_sent, results_checked, chars_out);
        $display("tb: idling phases none, sender, receiver and light on both sides");
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== utf8_to_cp874_transcoder_unit.f =====
rtl/u2c_pkg.sv
rtl/u2c_map.sv
rtl/utf8_to_cp874_transcoder_unit.sv
verif/tb.sv
